// File: rtl/xxh_pkg.sv
// ----------------------------------------------------------------------------
// xxh_pkg
// Shared types, constants and helpers of the XXH64 stream hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package xxh_pkg;

  localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
  localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;
  localparam logic [63:0] PRIME12 = PRIME1 + PRIME2;

  localparam logic [3:0] FULL_BYTES = 4'd8;
  localparam logic [3:0] HALF_BYTES = 4'd4;
  localparam logic [1:0] LANE_LAST = 2'd3;
  localparam logic [1:0] PEND_FULL = 2'd3;

  // Datapath operations
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_STORE,
    DP_BT_ADD_N,
    DP_MUL,
    DP_RND_ADD_LANE,
    DP_RND_ADD_ZERO,
    DP_LANE_WR,
    DP_STRIPE_DONE,
    DP_H_MERGE_INIT,
    DP_H_SHORT_INIT,
    DP_H_ADD_BT,
    DP_H_XOR,
    DP_H_ROT27,
    DP_H_ROT23,
    DP_H_ROT11,
    DP_H_ADD_C,
    DP_H_FROM_PROD,
    DP_W_SHIFT4,
    DP_W_SHIFT1,
    DP_H_XSH33,
    DP_H_XSH29,
    DP_H_XSH32,
    DP_EMIT
  } dp_op_t;

  // Multiplier operand sources
  typedef enum logic [2:0] {
    SRC_WORD,
    SRC_LANE,
    SRC_T,
    SRC_H,
    SRC_W32,
    SRC_BYTE
  } src_t;

  typedef enum logic [2:0] {
    C_PR1,
    C_PR2,
    C_PR3,
    C_PR4,
    C_PR5
  } cst_t;

  typedef struct packed {
    dp_op_t     op;
    src_t       src;
    cst_t       cst;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic       push;
    logic       last;
    logic [1:0] pcnt;
    logic       stripe;
    logic [3:0] n;
    logic       mul_done;
    logic       out_full;
  } dp_sts_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_DECIDE,
    S_MWAIT,
    S_R1, S_R2, S_R3, S_R4,
    S_SDONE,
    S_HINIT,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
    S_HBT,
    S_TCHK,
    S_P2, S_P3, S_P4, S_P5, S_P6, S_P7,
    S_Q2, S_Q3, S_Q4, S_Q5, S_Q6,
    S_B2, S_B3, S_B4, S_B5, S_B6,
    S_A1, S_A2, S_A3, S_A4, S_A5, S_A6,
    S_EMIT
  } state_t;

  function automatic logic [63:0] cst_value(input cst_t c);
    logic [63:0] v;
    case (c)
      C_PR1: v = PRIME1;
      C_PR2: v = PRIME2;
      C_PR3: v = PRIME3;
      C_PR4: v = PRIME4;
      C_PR5: v = PRIME5;
      default: v = PRIME1;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned s);
    return (v << s) | (v >> (64 - s));
  endfunction

endpackage

`default_nettype wire

// File: rtl/xxh_mul.sv
// ----------------------------------------------------------------------------
// xxh_mul
// 64 x 64 multiplier, low 64 bits of the product, one 32 x 32 product a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module xxh_mul
  import xxh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a_in,
  input  wire logic [63:0] b_in,
  output logic [63:0]      prod,
  output logic             done
);

  logic [63:0] a;
  logic [63:0] b;
  logic [1:0]  ph;
  logic        busy;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] pp;

  always_comb begin
    case (ph)
      2'd0: begin
        ma = a[31:0];
        mb = b[31:0];
      end
      2'd1: begin
        ma = a[63:32];
        mb = b[31:0];
      end
      default: begin
        ma = a[31:0];
        mb = b[63:32];
      end
    endcase
  end

  assign pp   = ma * mb;
  assign done = ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ph   <= 2'd0;
    end else if (start) begin
      busy <= 1'b1;
      ph   <= 2'd0;
    end else if (busy) begin
      if (ph == 2'd2) begin
        busy <= 1'b0;
      end
      ph <= ph + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a <= a_in;
      b <= b_in;
    end else if (busy) begin
      if (ph == 2'd0) begin
        prod <= pp;
      end else begin
        // cross terms only reach the upper half
        prod[63:32] <= prod[63:32] + pp[31:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/xxh_dp.sv
// ----------------------------------------------------------------------------
// xxh_dp
// Datapath: lanes, pending words, hash register, shared multiplier, result.
// ----------------------------------------------------------------------------
`default_nettype none

module xxh_dp
  import xxh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  input  wire logic [63:0] seed,
  input  wire logic [63:0] data_word,
  input  wire logic [3:0]  byte_count,
  input  wire logic        last_chunk,
  input  wire logic        out_stall,
  output dp_sts_t          sts,
  output logic [63:0]      hash_value,
  output logic             out_valid
);

  logic [63:0] lane [4];
  logic [63:0] pend [3];
  logic [1:0]  pcnt;
  logic [63:0] bt;
  logic        stripe;
  logic [63:0] w;
  logic [3:0]  n;
  logic        last;
  logic [63:0] h;
  logic [63:0] t;
  logic [63:0] word_sel;
  logic [63:0] mul_a;
  logic [63:0] prod;
  logic        mul_done;
  logic        mul_start;

  always_comb begin
    case (cmd.idx)
      2'd0: word_sel = pend[0];
      2'd1: word_sel = pend[1];
      2'd2: word_sel = pend[2];
      default: word_sel = w;
    endcase
  end

  always_comb begin
    case (cmd.src)
      SRC_WORD: mul_a = word_sel;
      SRC_LANE: mul_a = lane[cmd.idx];
      SRC_T:    mul_a = t;
      SRC_H:    mul_a = h;
      SRC_W32:  mul_a = {32'd0, w[31:0]};
      SRC_BYTE: mul_a = {56'd0, w[7:0]};
      default:  mul_a = h;
    endcase
  end

  assign mul_start = (cmd.op == DP_MUL);

  xxh_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a_in  (mul_a),
    .b_in  (cst_value(cmd.cst)),
    .prod  (prod),
    .done  (mul_done)
  );

  always_comb begin
    sts.push     = ~last | (n == FULL_BYTES);
    sts.last     = last;
    sts.pcnt     = pcnt;
    sts.stripe   = stripe;
    sts.n        = n;
    sts.mul_done = mul_done;
    sts.out_full = out_valid & out_stall;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt      <= 2'd0;
      bt        <= 64'd0;
      stripe    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && cmd.op != DP_EMIT) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        DP_LOAD: begin
          if (bt == 64'd0) begin
            pcnt   <= 2'd0;
            stripe <= 1'b0;
          end
        end
        DP_STORE: begin
          pcnt <= pcnt + 2'd1;
          bt   <= bt + 64'd8;
        end
        DP_STRIPE_DONE: begin
          pcnt   <= 2'd0;
          stripe <= 1'b1;
          bt     <= bt + 64'd8;
        end
        DP_BT_ADD_N: bt <= bt + {60'd0, n};
        DP_EMIT: begin
          out_valid <= 1'b1;
          pcnt      <= 2'd0;
          bt        <= 64'd0;
          stripe    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        w    <= data_word;
        n    <= (byte_count > FULL_BYTES) ? FULL_BYTES : byte_count;
        last <= last_chunk;
        if (bt == 64'd0) begin
          lane[0] <= seed + PRIME12;
          lane[1] <= seed + PRIME2;
          lane[2] <= seed;
          lane[3] <= seed - PRIME1;
        end
      end
      DP_STORE: begin
        case (pcnt)
          2'd0: pend[0] <= w;
          2'd1: pend[1] <= w;
          default: pend[2] <= w;
        endcase
        n <= 4'd0;
      end
      DP_STRIPE_DONE:  n <= 4'd0;
      DP_RND_ADD_LANE: t <= rotl(lane[cmd.idx] + prod, 31);
      DP_RND_ADD_ZERO: t <= rotl(prod, 31);
      DP_LANE_WR:      lane[cmd.idx] <= prod;
      DP_H_MERGE_INIT: h <= rotl(lane[0], 1) + rotl(lane[1], 7)
                          + rotl(lane[2], 12) + rotl(lane[3], 18);
      DP_H_SHORT_INIT: h <= lane[2] + PRIME5;
      DP_H_ADD_BT:     h <= h + bt;
      DP_H_XOR:        h <= h ^ prod;
      DP_H_ROT27:      h <= rotl(h, 27);
      DP_H_ROT23:      h <= rotl(h, 23);
      DP_H_ROT11:      h <= rotl(h, 11);
      DP_H_ADD_C:      h <= prod + cst_value(cmd.cst);
      DP_H_FROM_PROD:  h <= prod;
      DP_W_SHIFT4: begin
        w <= w >> 32;
        n <= n - HALF_BYTES;
      end
      DP_W_SHIFT1: begin
        w <= w >> 8;
        n <= n - 4'd1;
      end
      DP_H_XSH33:      h <= h ^ (h >> 33);
      DP_H_XSH29:      h <= h ^ (h >> 29);
      DP_H_XSH32:      h <= h ^ (h >> 32);
      DP_EMIT:         hash_value <= h;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_MUL) |-> mul_done)
    else $error("multiplier started while busy");
  a_store_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_STORE) |-> (pcnt != PEND_FULL))
    else $error("pending word store with no room");
  a_emit_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_EMIT) |=> (out_valid && bt == 64'd0 && pcnt == 2'd0 && !stripe))
    else $error("message state not cleared after result");
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_EMIT) |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

// File: rtl/xxh_ctrl.sv
// ----------------------------------------------------------------------------
// xxh_ctrl
// Sequencer: steps the datapath through lane rounds, merge, tail and avalanche.
// ----------------------------------------------------------------------------
`default_nettype none

module xxh_ctrl
  import xxh_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire dp_sts_t sts,
  output logic         in_stall,
  output dp_cmd_t      cmd
);

  state_t     state;
  state_t     state_next;
  state_t     ret;
  state_t     ret_next;
  logic [1:0] idx;
  logic [1:0] idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      idx   <= 2'd0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      idx   <= idx_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    ret_next   = ret;
    idx_next   = idx;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DECIDE;
      S_DECIDE: begin
        if (sts.push && sts.pcnt != PEND_FULL) begin
          state_next = sts.last ? S_HINIT : S_IDLE;
        end else if (sts.push) begin
          idx_next   = 2'd0;
          state_next = S_R1;
        end else begin
          state_next = S_HINIT;
        end
      end
      S_MWAIT: if (sts.mul_done) state_next = ret;
      S_R1: begin
        ret_next   = S_R2;
        state_next = S_MWAIT;
      end
      S_R2: state_next = S_R3;
      S_R3: begin
        ret_next   = S_R4;
        state_next = S_MWAIT;
      end
      S_R4: begin
        if (idx == LANE_LAST) begin
          state_next = S_SDONE;
        end else begin
          idx_next   = idx + 2'd1;
          state_next = S_R1;
        end
      end
      S_SDONE: state_next = sts.last ? S_HINIT : S_IDLE;
      S_HINIT: begin
        idx_next   = 2'd0;
        state_next = sts.stripe ? S_M1 : S_HBT;
      end
      S_M1: begin
        ret_next   = S_M2;
        state_next = S_MWAIT;
      end
      S_M2: state_next = S_M3;
      S_M3: begin
        ret_next   = S_M4;
        state_next = S_MWAIT;
      end
      S_M4: state_next = S_M5;
      S_M5: begin
        ret_next   = S_M6;
        state_next = S_MWAIT;
      end
      S_M6: begin
        if (idx == LANE_LAST) begin
          state_next = S_HBT;
        end else begin
          idx_next   = idx + 2'd1;
          state_next = S_M1;
        end
      end
      S_HBT: begin
        idx_next   = 2'd0;
        state_next = S_TCHK;
      end
      S_TCHK: begin
        state_next = S_MWAIT;
        if (idx < sts.pcnt) begin
          ret_next = S_P2;
        end else if (sts.n >= HALF_BYTES) begin
          ret_next = S_Q2;
        end else if (sts.n != 4'd0) begin
          ret_next = S_B2;
        end else begin
          state_next = S_A1;
        end
      end
      S_P2: state_next = S_P3;
      S_P3: begin
        ret_next   = S_P4;
        state_next = S_MWAIT;
      end
      S_P4: state_next = S_P5;
      S_P5: state_next = S_P6;
      S_P6: begin
        ret_next   = S_P7;
        state_next = S_MWAIT;
      end
      S_P7: begin
        idx_next   = idx + 2'd1;
        state_next = S_TCHK;
      end
      S_Q2: state_next = S_Q3;
      S_Q3: state_next = S_Q4;
      S_Q4: begin
        ret_next   = S_Q5;
        state_next = S_MWAIT;
      end
      S_Q5: state_next = S_Q6;
      S_Q6: state_next = S_TCHK;
      S_B2: state_next = S_B3;
      S_B3: state_next = S_B4;
      S_B4: begin
        ret_next   = S_B5;
        state_next = S_MWAIT;
      end
      S_B5: state_next = S_B6;
      S_B6: state_next = S_TCHK;
      S_A1: begin
        ret_next   = S_A2;
        state_next = S_MWAIT;
      end
      S_A2: state_next = S_A3;
      S_A3: state_next = S_A4;
      S_A4: begin
        ret_next   = S_A5;
        state_next = S_MWAIT;
      end
      S_A5: state_next = S_A6;
      S_A6: state_next = S_EMIT;
      S_EMIT: if (!sts.out_full) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = (state != S_IDLE);
    cmd.op   = DP_NOP;
    cmd.src  = SRC_H;
    cmd.cst  = C_PR1;
    cmd.idx  = idx;
    case (state)
      S_IDLE: if (in_valid) cmd.op = DP_LOAD;
      S_DECIDE: begin
        if (sts.push && sts.pcnt != PEND_FULL) begin
          cmd.op = DP_STORE;
        end else if (!sts.push) begin
          cmd.op = DP_BT_ADD_N;
        end
      end
      S_R1: begin
        cmd.op  = DP_MUL;
        cmd.src = SRC_WORD;
        cmd.cst = C_PR2;
      end
      S_R2: cmd.op = DP_RND_ADD_LANE;
      S_R3: begin
        cmd.op  = DP_MUL;
        cmd.src = SRC_T;
        cmd.cst = C_PR1;
      end
      S_R4:    cmd.op = DP_LANE_WR;
      S_SDONE: cmd.op = DP_STRIPE_DONE;
      S_HINIT: cmd.op = sts.stripe ? DP_H_MERGE_INIT : DP_H_SHORT_INIT;
      S_M1: begin
        cmd.op  = DP_MUL;
        cmd.src = SRC_LANE;
        cmd.cst = C_PR2;
      end
      S_M2: cmd.op = DP_RND_ADD_ZERO;
      S_M3: begin
        cmd.op  = DP_MUL;
        cmd.src = SRC_T;
        cmd.cst = C_PR1;
      end
      S_M4: cmd.op = DP_H_XOR;
      S_M5: begin
        cmd.op  = DP_MUL;
        cmd.src = SRC_H;
        cmd.cst = C_PR1;
      end
      S_M6: begin
        cmd.op  = DP_H_ADD_C;
        cmd.cst = C_PR4;
      end
      S_HBT: cmd.op = DP_H_ADD_BT;
      S_TCHK: begin
        cmd.op = DP_MUL;
        if (idx < sts.pcnt) begin
          cmd.src = SRC_WORD;
          cmd.cst = C_PR2;
        end else if (sts.n >= HALF_BYTES) begin
          cmd.src = SRC_W32;
          cmd.cst = C_PR1;
        end else if (sts.n != 4'd0) begin
          cmd.src = SRC_BYTE;
          cmd.cst = C_PR5;
        end else begin
          cmd.op = DP_H_XSH33;
        end
      end
      S_P2: cmd.op = DP_RND_ADD_ZERO;
      S_P3: begin
        cmd.op  = DP_MUL;
        cmd.src = SRC_T;
        cmd.cst = C_PR1;
      end
      S_P4: cmd.op = DP_H_XOR;
      S_P5: cmd.op = DP_H_ROT27;
      S_P6: begin
        cmd.op  = DP_MUL;
        cmd.cst = C_PR1;
      end
      S_P7: begin
        cmd.op  = DP_H_ADD_C;
        cmd.cst = C_PR4;
      end
      S_Q2: cmd.op = DP_H_XOR;
      S_Q3: cmd.op = DP_H_ROT23;
      S_Q4: begin
        cmd.op  = DP_MUL;
        cmd.cst = C_PR2;
      end
      S_Q5: begin
        cmd.op  = DP_H_ADD_C;
        cmd.cst = C_PR3;
      end
      S_Q6: cmd.op = DP_W_SHIFT4;
      S_B2: cmd.op = DP_H_XOR;
      S_B3: cmd.op = DP_H_ROT11;
      S_B4: begin
        cmd.op  = DP_MUL;
        cmd.cst = C_PR1;
      end
      S_B5: cmd.op = DP_H_FROM_PROD;
      S_B6: cmd.op = DP_W_SHIFT1;
      S_A1: begin
        cmd.op  = DP_MUL;
        cmd.cst = C_PR2;
      end
      S_A2: cmd.op = DP_H_FROM_PROD;
      S_A3: cmd.op = DP_H_XSH29;
      S_A4: begin
        cmd.op  = DP_MUL;
        cmd.cst = C_PR3;
      end
      S_A5: cmd.op = DP_H_FROM_PROD;
      S_A6: cmd.op = DP_H_XSH32;
      S_EMIT: if (!sts.out_full) cmd.op = DP_EMIT;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/xxh64_stream_hash.sv
// ----------------------------------------------------------------------------
// xxh64_stream_hash
// Streaming XXH64 hash over little-endian 64-bit words, seed via APB.
// ----------------------------------------------------------------------------
// One request is taken at a time. A word that only fills a pending slot is
// stored; the word that completes a 32-byte stripe runs the four lane rounds,
// each of which uses the single shared multiplier twice. A 64-bit multiply
// holds the sequencer while it is issued, three 32 x 32 partial products are
// formed and the done check is made. The last request then sets up the hash,
// merges the four lanes when a stripe was seen, adds the length, folds in each
// pending word, a 4-byte step and each single byte, and ends with the
// avalanche and result write, which can wait on out_stall. The result
// register lets the next request enter while a hash still waits on
// out_stall. The seed at address 0 is sampled at message start.
`default_nettype none

module xxh64_stream_hash
  import xxh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] data_word,
  input  wire logic [3:0]  byte_count,
  input  wire logic        last_chunk,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      hash_value,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0] seed;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? 64'd0 : seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 64'd0;
    end else if (psel && penable && pwrite && pready && !paddr[3]) begin
      seed <= pwdata;
    end
  end

  xxh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  xxh_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .seed       (seed),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last_chunk (last_chunk),
    .out_stall  (out_stall),
    .sts        (sts),
    .hash_value (hash_value),
    .out_valid  (out_valid)
  );

endmodule

`default_nettype wire
